// ===== rtl/core/rfae_pkg.sv =====
`default_nettype none
package rfae_pkg;

  localparam int RegCount = 256;
  localparam int IdxW = $clog2(RegCount);
  localparam int QueueDepth = 2;

  typedef enum logic [4:0] {
    CMD_MOV = 5'd0, CMD_CMOV = 5'd1, CMD_UCMP = 5'd2, CMD_SCMP = 5'd3,
    CMD_UTEST = 5'd4, CMD_STEST = 5'd5, CMD_SET = 5'd6, CMD_LNOT = 5'd7,
    CMD_BNOT = 5'd8, CMD_ADD = 5'd9, CMD_SUB = 5'd10, CMD_MUL = 5'd11,
    CMD_UDIV = 5'd12, CMD_SDIV = 5'd13, CMD_UREM = 5'd14, CMD_SREM = 5'd15,
    CMD_LSL = 5'd16, CMD_LSR = 5'd17, CMD_ASL = 5'd18, CMD_ASR = 5'd19,
    CMD_AND = 5'd20, CMD_OR = 5'd21, CMD_XOR = 5'd22, CMD_SEXT1 = 5'd23,
    CMD_SEXT8 = 5'd24, CMD_SEXT16 = 5'd25, CMD_SEXT32 = 5'd26
  } cmd_t;

  localparam logic [2:0] COND_EQ = 3'd0;
  localparam logic [2:0] COND_NE = 3'd1;
  localparam logic [2:0] COND_LT = 3'd2;
  localparam logic [2:0] COND_LE = 3'd3;
  localparam logic [2:0] COND_GT = 3'd4;
  localparam logic [2:0] COND_GE = 3'd5;

  typedef struct packed {
    logic [4:0]  command;
    logic [1:0]  width_code;
    logic        use_immediate;
    logic [2:0]  condition;
    logic [7:0]  dest_index;
    logic [7:0]  source_index;
    logic [63:0] immediate_value;
  } in_req_t;

  typedef struct packed {
    logic        wrote;
    logic [7:0]  written_index;
    logic [63:0] written_value;
    logic        less_flag;
    logic        equal_flag;
    logic        divide_by_zero;
  } out_req_t;

  // Decoded operation class, produced by the front end.
  typedef enum logic [2:0] {
    OC_SIMPLE, OC_MUL, OC_DIV, OC_NOP
  } op_class_t;

  typedef struct packed {
    in_req_t   req;
    op_class_t op_class;
  } dec_req_t;

  typedef enum logic [2:0] {
    EX_IDLE, EX_READ, EX_MULHI, EX_DIV, EX_FIN, EX_OUT
  } ex_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/rfae_ram.sv =====
`default_nettype none
module rfae_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr_a,
  input  wire logic [$clog2(Depth)-1:0] raddr_b,
  output      logic [Width-1:0]         rdata_a,
  output      logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfae_front.sv =====
`default_nettype none
module rfae_front
  import rfae_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire in_req_t  in_data,
  output      logic     q_valid,
  input  wire logic     q_pop,
  output      dec_req_t q_data
);

  dec_req_t                q_mem_r [QueueDepth];
  logic [0:0]              rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    push;
  dec_req_t                dec;

  // Classify the request by the unit it needs.
  always_comb begin
    dec.req = in_data;
    if (in_data.command == CMD_MUL) begin
      dec.op_class = OC_MUL;
    end else if (in_data.command >= CMD_UDIV && in_data.command <= CMD_SREM) begin
      dec.op_class = OC_DIV;
    end else if (in_data.command > CMD_SEXT32) begin
      dec.op_class = OC_NOP;
    end else begin
      dec.op_class = OC_SIMPLE;
    end
  end

  assign in_stall = (cnt_r == 2'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem_r[rd_ptr_r];

  // Queue pointers.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfae_div.sv =====
`default_nettype none
module rfae_div
  import rfae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        wide,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output      logic        done,
  output      logic [63:0] quotient,
  output      logic [63:0] remainder
);

  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  assign quotient  = q_r;
  assign remainder = rem_r[63:0];
  assign done      = busy_r && (cnt_r == 7'd0);

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[63:0], q_r[63]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = wide ? dividend : {dividend[31:0], 32'd0};
      rem_nxt  = '0;
      cnt_nxt  = wide ? 7'd64 : 7'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
        if (!trial[64]) begin
          rem_nxt = trial;
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[63:0], q_r[63]};
          q_nxt   = {q_r[62:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfae_back.sv =====
`default_nettype none
module rfae_back
  import rfae_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  output      logic     q_pop,
  input  wire dec_req_t q_data,
  output      logic     out_valid,
  input  wire logic     out_stall,
  output      out_req_t out_data
);

  ex_state_t   state_r, state_nxt;
  dec_req_t    cur_r;
  logic [RegCount-1:0] valid_r;
  logic         less_r, equal_r, less_nxt, equal_nxt;
  logic [63:0]  a, b, a_raw, b_raw;
  logic [63:0]  rd_a, rd_b;
  logic [7:0]   rf_raddr_a, rf_raddr_b;
  logic         a_ok_r, b_ok_r;
  logic         we;
  logic [63:0]  nv;
  logic         wr, dz;
  logic [31:0]  ml_a_lo, ml_b_lo;
  logic [63:0]  pp_ll_r, pp_lh_r, pp_hl_r;
  logic [63:0]  mres;
  logic         div_start, div_done;
  logic [63:0]  div_q, div_r, div_x, div_y;
  logic [63:0]  am, asb, x, y, r, cm, csb, p, qv;
  logic         wide, nx, ny, cond_ok;
  logic [5:0]   sh;
  out_req_t     res_r, res_nxt;
  cmd_t         cmd;

  // The read ports follow the request being taken, then keep reading the
  // current request's registers so its operands stay put until it finishes.
  assign rf_raddr_a = q_pop ? q_data.req.dest_index : cur_r.req.dest_index;
  assign rf_raddr_b = q_pop ? q_data.req.source_index : cur_r.req.source_index;

  // Register file: zero until first written, tracked with valid bits.
  rfae_ram #(.Width(64), .Depth(RegCount)) u_rf (
    .clk(clk), .we(we), .waddr(cur_r.req.dest_index), .wdata(nv),
    .raddr_a(rf_raddr_a), .raddr_b(rf_raddr_b),
    .rdata_a(rd_a), .rdata_b(rd_b)
  );

  assign a_raw = a_ok_r ? rd_a : 64'd0;
  assign b_raw = b_ok_r ? rd_b : 64'd0;
  assign a     = a_raw;
  assign b     = cur_r.req.use_immediate ? cur_r.req.immediate_value : b_raw;
  assign cmd   = cmd_t'(cur_r.req.command);

  assign wide = (cur_r.req.width_code == 2'd3);
  assign am   = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
  assign asb  = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
  assign x    = a & am;
  assign y    = b & am;
  assign nx   = |(x & asb);
  assign ny   = |(y & asb);

  // Compare width mask and sign bit.
  always_comb begin
    unique case (cur_r.req.width_code)
      2'd0: begin cm = 64'hFF; csb = 64'h80; end
      2'd1: begin cm = 64'hFFFF; csb = 64'h8000; end
      2'd2: begin cm = 64'hFFFF_FFFF; csb = 64'h8000_0000; end
      default: begin cm = '1; csb = 64'h8000_0000_0000_0000; end
    endcase
  end

  always_comb begin
    unique case (cur_r.req.condition)
      COND_EQ: cond_ok = equal_r;
      COND_NE: cond_ok = !equal_r;
      COND_LT: cond_ok = less_r;
      COND_LE: cond_ok = less_r || equal_r;
      COND_GT: cond_ok = !less_r && !equal_r;
      COND_GE: cond_ok = !less_r;
      default: cond_ok = 1'b0;
    endcase
  end

  // Multiplier as three registered 32x32 partial products.
  assign ml_a_lo = x[31:0];
  assign ml_b_lo = y[31:0];
  assign mres = pp_ll_r + {pp_lh_r[31:0] + pp_hl_r[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (state_r == EX_READ) begin
      pp_ll_r <= 64'(ml_a_lo) * 64'(ml_b_lo);
      pp_lh_r <= 64'(ml_a_lo) * 64'(y[63:32]);
      pp_hl_r <= 64'(x[63:32]) * 64'(ml_b_lo);
    end
  end

  // Divider operands are magnitudes for the signed forms.
  always_comb begin
    div_x = x;
    div_y = y;
    if (cmd == CMD_SDIV || cmd == CMD_SREM) begin
      div_x = nx ? ((64'd0 - x) & am) : x;
      div_y = ny ? ((64'd0 - y) & am) : y;
    end
  end

  rfae_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .wide(wide),
    .dividend(div_x), .divisor(div_y), .done(div_done),
    .quotient(div_q), .remainder(div_r)
  );

  // Result computation for the current request.
  always_comb begin
    r         = '0;
    nv        = '0;
    wr        = 1'b0;
    dz        = 1'b0;
    less_nxt  = less_r;
    equal_nxt = equal_r;
    p         = a & cm;
    qv        = b & cm;
    sh        = wide ? (cur_r.req.use_immediate ? cur_r.req.immediate_value[5:0] : y[5:0])
                     : {1'b0, (cur_r.req.use_immediate ? cur_r.req.immediate_value[4:0]
                                                       : y[4:0])};
    if (cmd >= CMD_ADD && cmd <= CMD_XOR) begin
      unique case (cmd)
        CMD_ADD: r = x + y;
        CMD_SUB: r = x - y;
        CMD_MUL: r = mres;
        CMD_UDIV, CMD_UREM, CMD_SDIV, CMD_SREM: begin
          if (y == 64'd0) begin
            dz = 1'b1;
            r  = (cmd == CMD_UDIV || cmd == CMD_SDIV) ? am : x;
          end else if (cmd == CMD_UDIV) begin
            r = div_q;
          end else if (cmd == CMD_UREM) begin
            r = div_r;
          end else if (cmd == CMD_SDIV) begin
            r = (nx != ny) ? ((64'd0 - div_q) & am) : div_q;
          end else begin
            r = nx ? ((64'd0 - div_r) & am) : div_r;
          end
        end
        CMD_LSL, CMD_ASL: r = x << sh;
        CMD_LSR: r = x >> sh;
        CMD_ASR: r = nx ? ((x >> sh) | (am & ~(am >> sh))) : (x >> sh);
        CMD_AND: r = x & y;
        CMD_OR:  r = x | y;
        default: r = x ^ y;
      endcase
      nv = (a & ~am) | (r & am);
      wr = 1'b1;
    end else begin
      unique case (cur_r.req.command)
        CMD_MOV: begin nv = b; wr = 1'b1; end
        CMD_CMOV: begin nv = b; wr = cond_ok; end
        CMD_UCMP, CMD_SCMP: begin
          if (cmd == CMD_SCMP) begin
            p  = p ^ csb;
            qv = qv ^ csb;
          end
          less_nxt  = p < qv;
          equal_nxt = p == qv;
        end
        CMD_UTEST, CMD_STEST: begin
          less_nxt  = (cmd == CMD_STEST) && |(p & csb);
          equal_nxt = (p == 64'd0);
        end
        CMD_SET:    begin nv = {63'd0, cond_ok}; wr = 1'b1; end
        CMD_LNOT:   begin nv = {63'd0, a == 64'd0}; wr = 1'b1; end
        CMD_BNOT:   begin nv = ~a; wr = 1'b1; end
        CMD_SEXT1:  begin nv = {64{a[0]}}; wr = 1'b1; end
        CMD_SEXT8:  begin nv = {{56{a[7]}}, a[7:0]}; wr = 1'b1; end
        CMD_SEXT16: begin nv = {{48{a[15]}}, a[15:0]}; wr = 1'b1; end
        CMD_SEXT32: begin nv = {{32{a[31]}}, a[31:0]}; wr = 1'b1; end
        default: ;
      endcase
    end
    if (!wr) begin
      nv = '0;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EX_IDLE: if (q_valid) state_nxt = EX_READ;
      EX_READ: begin
        if (cur_r.op_class == OC_MUL) begin
          state_nxt = EX_MULHI;
        end else if (cur_r.op_class == OC_DIV) begin
          state_nxt = EX_DIV;
        end else begin
          state_nxt = EX_FIN;
        end
      end
      EX_MULHI: state_nxt = EX_FIN;
      EX_DIV:   if (div_done) state_nxt = EX_FIN;
      EX_FIN:   state_nxt = EX_OUT;
      EX_OUT:   if (!out_stall) state_nxt = EX_IDLE;
      default:  state_nxt = EX_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop     = (state_r == EX_IDLE) && q_valid;
    div_start = (state_r == EX_READ) && (cur_r.op_class == OC_DIV);
    we        = (state_r == EX_FIN) && wr;
    out_valid = (state_r == EX_OUT);
    res_nxt.wrote          = wr;
    res_nxt.written_index  = wr ? cur_r.req.dest_index : 8'd0;
    res_nxt.written_value  = nv;
    res_nxt.less_flag      = less_nxt;
    res_nxt.equal_flag     = equal_nxt;
    res_nxt.divide_by_zero = dz;
  end

  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EX_IDLE;
      valid_r <= '0;
      less_r  <= 1'b0;
      equal_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (we) begin
        valid_r[cur_r.req.dest_index] <= 1'b1;
      end
      if (state_r == EX_FIN) begin
        less_r  <= less_nxt;
        equal_r <= equal_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r  <= q_data;
      a_ok_r <= valid_r[q_data.req.dest_index];
      b_ok_r <= valid_r[q_data.req.source_index];
    end
    if (state_r == EX_FIN) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/register_file_alu_execute.sv =====
`default_nettype none
// Integer execute block over 256 64-bit registers and a less/equal flag pair.
// A front queue of two requests takes instructions while the back end works.
// The back end handles one instruction at a time: a read state at the register
// file port, a compute state and an output state for most instructions, plus an
// extra state for mul (partial products registered) and a divide state for
// divide and remainder (one quotient bit per cycle at 32 or 64 bits). A result
// waits in the output register until taken. No clearing pass is needed after
// reset: per-register valid bits make unwritten registers read as zero.
module register_file_alu_execute
  import rfae_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire in_req_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_stall,
  output      out_req_t out_data
);

  logic     q_valid, q_pop;
  dec_req_t q_data;

  rfae_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  rfae_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ===== test/rfae_checker.sv =====
module rfae_checker
  import rfae_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_req_t out_data,
  output int       fail_count,
  output int       pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] regs [0:RegCount-1];
  logic        less_q;
  logic        equal_q;
  out_req_t    expected_results [$];
  int          mismatches;

  assign fail_count = mismatches;
  assign pending_count = expected_results.size();

  // Evaluates a condition code against the current flags.
  function automatic logic cond_true(logic [2:0] c);
    case (c)
      COND_EQ: return equal_q;
      COND_NE: return !equal_q;
      COND_LT: return less_q;
      COND_LE: return less_q || equal_q;
      COND_GT: return !less_q && !equal_q;
      COND_GE: return !less_q;
      default: return 1'b0;
    endcase
  endfunction

  // Executes one instruction on the shadow register file and flags.
  function automatic out_req_t execute_instr(in_req_t r);
    out_req_t    res;
    logic [7:0]  d;
    logic [63:0] a, b, am, asb, cm, csb, x, y, rv, nv, ux, uy, p, q;
    int          cbits, n;
    logic        wr, dz, nx, ny;
    cmd_t        c;
    d = r.dest_index % RegCount;
    a = regs[d];
    b = r.use_immediate ? r.immediate_value : regs[r.source_index % RegCount];
    wr = 0; dz = 0; nv = 0; rv = 0;
    cbits = 8 << r.width_code;
    cm = (cbits == 64) ? '1 : ((64'd1 << cbits) - 1);
    csb = 64'd1 << (cbits - 1);
    am = (r.width_code == 2'd3) ? '1 : 64'hFFFF_FFFF;
    asb = (r.width_code == 2'd3) ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    x = a & am;
    y = b & am;
    c = cmd_t'(r.command);
    if (r.command >= CMD_ADD && r.command <= CMD_XOR) begin
      case (c)
        CMD_ADD: rv = x + y;
        CMD_SUB: rv = x - y;
        CMD_MUL: rv = x * y;
        CMD_UDIV, CMD_UREM: begin
          if (y == 0) begin
            dz = 1;
            rv = (c == CMD_UDIV) ? am : x;
          end else begin
            rv = (c == CMD_UDIV) ? x / y : x % y;
          end
        end
        CMD_SDIV, CMD_SREM: begin
          if (y == 0) begin
            dz = 1;
            rv = (c == CMD_SDIV) ? am : x;
          end else begin
            nx = (x & asb) != 0;
            ny = (y & asb) != 0;
            ux = nx ? ((64'd0 - x) & am) : x;
            uy = ny ? ((64'd0 - y) & am) : y;
            if (c == CMD_SDIV) begin
              rv = ux / uy;
              if (nx != ny) rv = (64'd0 - rv) & am;
            end else begin
              rv = ux % uy;
              if (nx) rv = (64'd0 - rv) & am;
            end
          end
        end
        CMD_LSL, CMD_LSR, CMD_ASL, CMD_ASR: begin
          // Shift amount wraps at the operand width.
          n = r.use_immediate ? (r.immediate_value[7:0] % ((r.width_code == 2'd3) ? 64 : 32))
                              : (y % ((r.width_code == 2'd3) ? 64 : 32));
          if (c == CMD_LSL || c == CMD_ASL) begin
            rv = x << n;
          end else begin
            rv = x >> n;
            if (c == CMD_ASR && (x & asb) != 0) rv |= am & ~(am >> n);
          end
        end
        CMD_AND: rv = x & y;
        CMD_OR:  rv = x | y;
        default: rv = x ^ y;
      endcase
      nv = (a & ~am) | (rv & am);
      wr = 1;
    end else begin
      case (r.command)
        CMD_MOV: begin nv = b; wr = 1; end
        CMD_CMOV: if (cond_true(r.condition)) begin nv = b; wr = 1; end
        CMD_UCMP, CMD_SCMP: begin
          p = a & cm;
          q = b & cm;
          if (r.command == CMD_SCMP) begin p ^= csb; q ^= csb; end
          less_q = p < q;
          equal_q = p == q;
        end
        CMD_UTEST, CMD_STEST: begin
          p = a & cm;
          less_q = (r.command == CMD_STEST) && ((p & csb) != 0);
          equal_q = p == 0;
        end
        CMD_SET: begin nv = cond_true(r.condition) ? 64'd1 : 64'd0; wr = 1; end
        CMD_LNOT: begin nv = (a == 0) ? 64'd1 : 64'd0; wr = 1; end
        CMD_BNOT: begin nv = ~a; wr = 1; end
        CMD_SEXT1: begin nv = a[0] ? '1 : '0; wr = 1; end
        CMD_SEXT8: begin nv = {{56{a[7]}}, a[7:0]}; wr = 1; end
        CMD_SEXT16: begin nv = {{48{a[15]}}, a[15:0]}; wr = 1; end
        CMD_SEXT32: begin nv = {{32{a[31]}}, a[31:0]}; wr = 1; end
        default: ;
      endcase
    end
    if (wr) regs[d] = nv;
    res.wrote = wr;
    res.written_index = wr ? d : 8'd0;
    res.written_value = wr ? nv : 64'd0;
    res.less_flag = less_q;
    res.equal_flag = equal_q;
    res.divide_by_zero = dz;
    return res;
  endfunction

  // Predicts on accepted requests and compares accepted results.
  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      for (int k = 0; k < RegCount; k++) regs[k] = '0;
      less_q = 0;
      equal_q = 0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(execute_instr(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.wrote !== want.wrote || out_data.written_index !== want.written_index ||
              out_data.written_value !== want.written_value ||
              out_data.less_flag !== want.less_flag ||
              out_data.equal_flag !== want.equal_flag ||
              out_data.divide_by_zero !== want.divide_by_zero) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_register_file_alu_execute.sv =====
module tb_register_file_alu_execute;
  import rfae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;
  int       fail_count;
  int       pending_count;
  int       cycle_count = 0;
  logic     sink_hold;
  logic     random_stall;

  register_file_alu_execute i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rfae_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  assign out_stall = sink_hold || random_stall;

  // Picks an operand value biased toward the edges of each width.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'h8000_0000;
      5: return 64'hFFFF_FFFF;
      6: return 64'($urandom_range(0, 70));
      7: return {32'h0, $urandom()} | 64'hFFFF_FFFF_0000_0000 * $urandom_range(0, 1);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Builds a random request; most use a small set of registers so values chain.
  function automatic in_req_t random_req();
    in_req_t r;
    r.command = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(27, 31))
                                             : 5'($urandom_range(0, 26));
    if ((r.command == CMD_UDIV || r.command == CMD_SDIV || r.command == CMD_UREM ||
         r.command == CMD_SREM) && $urandom_range(0, 2) != 0)
      r.command = CMD_ADD + 5'($urandom_range(0, 2));
    r.width_code = 2'($urandom_range(0, 3));
    r.use_immediate = 1'($urandom_range(0, 1));
    r.condition = 3'($urandom_range(0, 7));
    r.dest_index = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
    r.source_index = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
    r.immediate_value = pick_value();
    return r;
  endfunction

  // Offers one request and holds it until accepted; valid drops only for a gap.
  task automatic send_req(in_req_t r, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_req_t make_req(cmd_t c, logic [1:0] w, logic imm, logic [2:0] cnd,
                                       logic [7:0] d, logic [7:0] s, logic [63:0] v);
    in_req_t r;
    r.command = c; r.width_code = w; r.use_immediate = imm; r.condition = cnd;
    r.dest_index = d; r.source_index = s; r.immediate_value = v;
    return r;
  endfunction

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver random stalls, drawn per result.
  initial begin
    int wait_cycles;
    random_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (wait_cycles != 0) begin
        random_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      random_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // One long receiver hold-off, early in the random part.
  initial begin
    sink_hold = 1'b1;
    @(posedge rst_n);
    sink_hold <= 1'b0;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    in_req_t r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: edge values, compares, divide corner cases, bad conditions, no-ops.
    send_req(make_req(CMD_MOV, 2'd3, 1, COND_EQ, 8'd0, 8'd0, 64'h8000_0000_0000_0000), 0);
    send_req(make_req(CMD_MOV, 2'd3, 1, COND_EQ, 8'd1, 8'd0, '1), 0);
    send_req(make_req(CMD_MOV, 2'd3, 1, COND_EQ, 8'd255, 8'd0, 64'h8000_0000), 1);
    send_req(make_req(CMD_SDIV, 2'd3, 0, COND_EQ, 8'd0, 8'd1, 0), 0);
    send_req(make_req(CMD_SREM, 2'd2, 1, COND_EQ, 8'd255, 8'd0, 64'hFFFF_FFFF), 0);
    send_req(make_req(CMD_UDIV, 2'd3, 1, COND_EQ, 8'd1, 8'd0, 0), 0);
    send_req(make_req(CMD_SREM, 2'd2, 0, COND_EQ, 8'd255, 8'd7, 0), 2);
    send_req(make_req(CMD_SCMP, 2'd0, 1, COND_EQ, 8'd255, 8'd0, 64'h7F), 0);
    send_req(make_req(CMD_CMOV, 2'd3, 1, COND_LT, 8'd2, 8'd0, 64'h1234), 0);
    send_req(make_req(CMD_SET, 2'd3, 0, 3'd6, 8'd3, 8'd0, 0), 0);
    send_req(make_req(CMD_CMOV, 2'd3, 1, 3'd7, 8'd3, 8'd0, 64'h55), 0);
    send_req(make_req(CMD_UCMP, 2'd1, 0, COND_EQ, 8'd4, 8'd5, 0), 0);
    send_req(make_req(CMD_SET, 2'd3, 0, COND_EQ, 8'd6, 8'd0, 0), 0);
    send_req(make_req(CMD_STEST, 2'd3, 0, COND_EQ, 8'd0, 8'd0, 0), 0);
    send_req(make_req(CMD_UTEST, 2'd3, 0, COND_GE, 8'd1, 8'd0, 0), 0);
    send_req(make_req(CMD_ASR, 2'd3, 1, COND_EQ, 8'd1, 8'd0, 64'hFF), 0);
    send_req(make_req(CMD_LSL, 2'd2, 1, COND_EQ, 8'd1, 8'd0, 64'h21), 0);
    send_req(make_req(CMD_SEXT1, 2'd3, 0, COND_EQ, 8'd1, 8'd0, 0), 0);
    send_req(make_req(CMD_SEXT32, 2'd3, 0, COND_EQ, 8'd255, 8'd0, 0), 0);
    send_req(make_req(CMD_LNOT, 2'd3, 0, COND_EQ, 8'd9, 8'd0, 0), 0);
    send_req(make_req(CMD_BNOT, 2'd3, 0, COND_EQ, 8'd9, 8'd0, 0), 0);
    r = make_req(CMD_MOV, 2'd3, 0, COND_EQ, 8'd9, 8'd0, 0);
    r.command = 5'd31;
    send_req(r, 0);

    // Random part; pause once for the block to drain completely.
    for (int k = 0; k < 1530; k++) begin
      if (k == 700) begin
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
      end
      send_req(random_req(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/rfae_pkg.sv
rtl/core/rfae_ram.sv
rtl/core/rfae_front.sv
rtl/core/rfae_div.sv
rtl/core/rfae_back.sv
rtl/core/register_file_alu_execute.sv
test/rfae_checker.sv
test/tb_register_file_alu_execute.sv
